/* rtl/vdm_pkg.sv */
// ----------------------------------------------------------------------------
// vdm_pkg - shared types and constants of the virtqueue descriptor manager
// Descriptor table size, command and result records, result kinds and the
// configuration register map.
// ----------------------------------------------------------------------------
package vdm_pkg;

    // descriptor table
    localparam int NUM_DESC = 8;
    localparam int IDX_W    = $clog2(NUM_DESC);

    // fixed field widths
    localparam int OUT_IDX_W = 3;
    localparam int HEAD_W    = 8;
    localparam int LEN_W     = 17;
    localparam int ADDR_W    = 64;
    localparam int BLK_W     = 32;
    localparam int SPB_W     = 8;
    localparam int PROD_W    = BLK_W + SPB_W;

    // stream packing
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 160;
    localparam int CFG_IDX_W = 2;

    // command queue between front and back end
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // descriptor flag bits
    localparam logic [1:0] FL_NEXT  = 2'b01;
    localparam logic [1:0] FL_WRITE = 2'b10;

    // descriptor lengths
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(16);
    localparam logic [LEN_W-1:0] STS_LEN = LEN_W'(1);

    // configuration reset values
    localparam logic [SPB_W-1:0]  SPB_RST      = SPB_W'(2);
    localparam logic [LEN_W-1:0]  DATA_LEN_RST = LEN_W'(1024);
    localparam logic [ADDR_W-1:0] BASE_RST     = '0;

    typedef enum logic {
        OP_SUBMIT   = 1'b0,
        OP_COMPLETE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        KIND_DESC    = 3'd0,
        KIND_AVAIL   = 3'd1,
        KIND_NOSPACE = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_BADSTAT = 3'd4,
        KIND_FREEERR = 3'd5
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPB      = 2'd0,
        CFG_DATA_LEN = 2'd1,
        CFG_HDR_BASE = 2'd2,
        CFG_STS_BASE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [SPB_W-1:0]  spb;
        logic [LEN_W-1:0]  data_len;
        logic [ADDR_W-1:0] hdr_base;
        logic [ADDR_W-1:0] sts_base;
    } t_cfg;

    // classified command handed from front end to back end
    typedef struct packed {
        t_op               opcode;
        logic              is_write;
        logic [ADDR_W-1:0] sector;
        logic [ADDR_W-1:0] data_address;
        logic [HEAD_W-1:0] head;
        logic              status_bad;
    } t_cmd;

    typedef struct packed {
        t_kind                kind;
        logic [OUT_IDX_W-1:0] desc_index;
        logic [ADDR_W-1:0]    desc_address;
        logic [LEN_W-1:0]     desc_length;
        logic [1:0]           desc_flags;
        logic [OUT_IDX_W-1:0] desc_next;
        logic [OUT_IDX_W-1:0] ring_slot;
        logic                 request_type;
        logic [ADDR_W-1:0]    sector;
        logic                 last;
    } t_result;

endpackage

/* rtl/virtqueue_descriptor_manager_unit.sv */
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_unit - split virtqueue block request driver
// Submit: 4 results, one per cycle while the output accepts, or one no-space result.
// Complete: pop, free one descriptor per cycle along the chain, then report.
// Reset: synchronous active low; all descriptors free, links and avail index
// zero, configuration at defaults; ready in the cycle after reset.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // is_write[0], block_number[32:1], data_address[96:33],
    // head_index[104:97], device_status[112:105], zero pad[119:113]
    input  logic [vdm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // opcode[0]
    input  logic                          i_s_axis_tuser,
    // master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // desc_index[2:0], desc_address[66:3], desc_length[83:67], desc_flags[85:84],
    // desc_next[88:86], ring_slot[91:89], request_type[92], sector[156:93],
    // zero pad[159:157]
    output logic [vdm_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // kind[2:0]
    output logic [2:0]                    o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [vdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vdm_pkg::ADDR_W-1:0]    i_cfg_data
);
    import vdm_pkg::*;

    t_cfg    r_cfg;
    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_pop;
    logic    w_q_empty;
    t_cmd    w_push_cmd;
    t_cmd    w_pop_cmd;
    t_result w_res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spb      <= SPB_RST;
            r_cfg.data_len <= DATA_LEN_RST;
            r_cfg.hdr_base <= BASE_RST;
            r_cfg.sts_base <= BASE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SPB:      r_cfg.spb      <= i_cfg_data[SPB_W-1:0];
                CFG_DATA_LEN: r_cfg.data_len <= i_cfg_data[LEN_W-1:0];
                CFG_HDR_BASE: r_cfg.hdr_base <= i_cfg_data;
                CFG_STS_BASE: r_cfg.sts_base <= i_cfg_data;
            endcase
        end
    end

    vdm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg           (r_cfg),
        .i_q_full        (w_q_full),
        .o_q_push        (w_q_push),
        .o_q_cmd         (w_push_cmd)
    );

    vdm_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_cmd   (w_pop_cmd)
    );

    vdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_pop_cmd),
        .o_q_pop     (w_q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready),
        .o_res       (w_res)
    );

    // result packing
    assign o_m_axis_tuser = w_res.kind;
    assign o_m_axis_tlast = w_res.last;
    assign o_m_axis_tdata = {3'b000, w_res.sector, w_res.request_type, w_res.ring_slot,
                             w_res.desc_next, w_res.desc_flags, w_res.desc_length,
                             w_res.desc_address, w_res.desc_index};

    // descriptor writes never close an item
    a_desc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == KIND_DESC)) |-> !o_m_axis_tlast)
        else $error("descriptor write marked last");

    // every other result kind closes its item
    a_other_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_DESC)) |-> o_m_axis_tlast)
        else $error("closing result without last");

    // sector and request type appear only on descriptor writes
    a_sector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != KIND_DESC)) |-> (o_m_axis_tdata[156:92] == '0))
        else $error("header fields on a non-descriptor result");

endmodule

/* rtl/vdm_front.sv */
// ----------------------------------------------------------------------------
// vdm_front - input stage
// Takes input transfers, splits the opcode, computes the header sector and
// reduces the device status to a pass/fail bit before queueing the command.
// ----------------------------------------------------------------------------
module vdm_front (
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [vdm_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                         i_s_axis_tuser,
    input  vdm_pkg::t_cfg                i_cfg,
    input  logic                         i_q_full,
    output logic                         o_q_push,
    output vdm_pkg::t_cmd                o_q_cmd
);
    import vdm_pkg::*;

    logic [BLK_W-1:0]  w_block;
    logic [PROD_W-1:0] w_product;
    logic [7:0]        w_status;

    // field unpack
    assign w_block  = i_s_axis_tdata[32:1];
    assign w_status = i_s_axis_tdata[112:105];

    // sector = block number * sectors per block
    assign w_product = {{SPB_W{1'b0}}, w_block} * {{BLK_W{1'b0}}, i_cfg.spb};

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_cmd              = '0;
        o_q_cmd.opcode       = t_op'(i_s_axis_tuser);
        o_q_cmd.is_write     = i_s_axis_tdata[0];
        o_q_cmd.sector       = ADDR_W'(w_product);
        o_q_cmd.data_address = i_s_axis_tdata[96:33];
        o_q_cmd.head         = i_s_axis_tdata[104:97];
        o_q_cmd.status_bad   = |w_status;
    end

endmodule

/* rtl/vdm_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// vdm_cmd_fifo - command queue
// Short queue of classified commands so front and back end stall apart.
// ----------------------------------------------------------------------------
module vdm_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vdm_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output vdm_pkg::t_cmd o_cmd
);
    import vdm_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  w_do_push;
    logic                  w_do_pop;

    assign o_full    = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/vdm_back.sv */
// ----------------------------------------------------------------------------
// vdm_back - descriptor sequencer
// Owns the free map, chain links and avail index. Emits the four submit
// results (or a no-space result) one per cycle while the output accepts, or
// walks and frees a completed chain one descriptor per cycle, into a registered output stage.
// ----------------------------------------------------------------------------
module vdm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vdm_pkg::t_cfg    i_cfg,
    input  logic             i_q_empty,
    input  vdm_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output vdm_pkg::t_result o_res
);
    import vdm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUBMIT,
        ST_WALK,
        ST_REPORT
    } t_state;

    typedef enum logic [1:0] {
        SUB_DATA,
        SUB_STATUS,
        SUB_AVAIL
    } t_sub_step;

    // lowest set bit of a map: {found, index}
    function automatic logic [IDX_W:0] first_free(input logic [NUM_DESC-1:0] m);
        logic [IDX_W:0] res;
        res = '0;
        for (int i = NUM_DESC - 1; i >= 0; i--) begin
            if (m[i]) begin
                res = {1'b1, IDX_W'(i)};
            end
        end
        return res;
    endfunction

    t_state            r_state, n_state;
    logic [NUM_DESC-1:0] r_free, n_free;
    logic              r_chain [NUM_DESC];
    logic              n_chain [NUM_DESC];
    logic [IDX_W-1:0]  r_next [NUM_DESC];
    logic [IDX_W-1:0]  n_next [NUM_DESC];
    logic [15:0]       r_avail_idx, n_avail_idx;
    t_sub_step         r_step, n_step;
    logic [IDX_W-1:0]  r_pick0, n_pick0;
    logic [IDX_W-1:0]  r_pick1, n_pick1;
    logic [IDX_W-1:0]  r_pick2, n_pick2;
    logic              r_is_write, n_is_write;
    logic [ADDR_W-1:0] r_data_addr, n_data_addr;
    logic [HEAD_W-1:0] r_head, n_head;
    logic [HEAD_W-1:0] r_cur, n_cur;
    logic [IDX_W-1:0]  r_walk_cnt, n_walk_cnt;
    logic              r_err, n_err;
    logic              r_bad, n_bad;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    logic [IDX_W:0]      w_f0, w_f1, w_f2;
    logic [NUM_DESC-1:0] w_bit0, w_bit1, w_bit2;
    logic                w_space;
    logic                w_can_emit;
    logic                w_in_range;
    logic [IDX_W-1:0]    w_cur_idx;

    // three lowest free descriptors
    assign w_f0    = first_free(r_free);
    assign w_bit0  = NUM_DESC'(1) << w_f0[IDX_W-1:0];
    assign w_f1    = first_free(r_free & ~w_bit0);
    assign w_bit1  = NUM_DESC'(1) << w_f1[IDX_W-1:0];
    assign w_f2    = first_free(r_free & ~w_bit0 & ~w_bit1);
    assign w_bit2  = NUM_DESC'(1) << w_f2[IDX_W-1:0];
    assign w_space = w_f0[IDX_W] && w_f1[IDX_W] && w_f2[IDX_W];

    assign w_can_emit = !r_out_valid || i_res_ready;
    assign w_in_range = ({1'b0, r_cur} < (HEAD_W + 1)'(NUM_DESC));
    assign w_cur_idx  = r_cur[IDX_W-1:0];

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // next-state and result selection
    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_chain     = r_chain;
        n_next      = r_next;
        n_avail_idx = r_avail_idx;
        n_step      = r_step;
        n_pick0     = r_pick0;
        n_pick1     = r_pick1;
        n_pick2     = r_pick2;
        n_is_write  = r_is_write;
        n_data_addr = r_data_addr;
        n_head      = r_head;
        n_cur       = r_cur;
        n_walk_cnt  = r_walk_cnt;
        n_err       = r_err;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && w_can_emit) begin
                    o_q_pop = 1'b1;
                    if (i_q_cmd.opcode == OP_SUBMIT) begin
                        n_out       = '0;
                        n_out_valid = 1'b1;
                        if (w_space) begin
                            n_free                       = r_free & ~(w_bit0 | w_bit1 | w_bit2);
                            n_chain[w_f0[IDX_W-1:0]]     = 1'b1;
                            n_next[w_f0[IDX_W-1:0]]      = w_f1[IDX_W-1:0];
                            n_chain[w_f1[IDX_W-1:0]]     = 1'b1;
                            n_next[w_f1[IDX_W-1:0]]      = w_f2[IDX_W-1:0];
                            n_chain[w_f2[IDX_W-1:0]]     = 1'b0;
                            n_next[w_f2[IDX_W-1:0]]      = '0;
                            n_pick0     = w_f0[IDX_W-1:0];
                            n_pick1     = w_f1[IDX_W-1:0];
                            n_pick2     = w_f2[IDX_W-1:0];
                            n_is_write  = i_q_cmd.is_write;
                            n_data_addr = i_q_cmd.data_address;
                            n_step      = SUB_DATA;
                            n_state     = ST_SUBMIT;
                            // header descriptor
                            n_out.kind         = KIND_DESC;
                            n_out.desc_index   = OUT_IDX_W'(w_f0[IDX_W-1:0]);
                            n_out.desc_address = i_cfg.hdr_base
                                               + ADDR_W'({w_f0[IDX_W-1:0], 4'b0000});
                            n_out.desc_length  = HDR_LEN;
                            n_out.desc_flags   = FL_NEXT;
                            n_out.desc_next    = OUT_IDX_W'(w_f1[IDX_W-1:0]);
                            n_out.request_type = i_q_cmd.is_write;
                            n_out.sector       = i_q_cmd.sector;
                        end else begin
                            n_out.kind = KIND_NOSPACE;
                            n_out.last = 1'b1;
                        end
                    end else begin
                        n_head     = i_q_cmd.head;
                        n_cur      = i_q_cmd.head;
                        n_bad      = i_q_cmd.status_bad;
                        n_err      = 1'b0;
                        n_walk_cnt = '0;
                        n_state    = ST_WALK;
                    end
                end
            end

            ST_SUBMIT: begin
                if (w_can_emit) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    unique case (r_step)
                        SUB_DATA: begin
                            n_out.kind         = KIND_DESC;
                            n_out.desc_index   = OUT_IDX_W'(r_pick1);
                            n_out.desc_address = r_data_addr;
                            n_out.desc_length  = i_cfg.data_len;
                            n_out.desc_flags   = r_is_write ? FL_NEXT : (FL_NEXT | FL_WRITE);
                            n_out.desc_next    = OUT_IDX_W'(r_pick2);
                            n_step             = SUB_STATUS;
                        end
                        SUB_STATUS: begin
                            n_out.kind         = KIND_DESC;
                            n_out.desc_index   = OUT_IDX_W'(r_pick2);
                            n_out.desc_address = i_cfg.sts_base
                                               + ADDR_W'({r_pick0, 4'b0000});
                            n_out.desc_length  = STS_LEN;
                            n_out.desc_flags   = FL_WRITE;
                            n_step             = SUB_AVAIL;
                        end
                        default: begin
                            // avail ring slot; slot is avail index mod table size
                            n_out.kind       = KIND_AVAIL;
                            n_out.desc_index = OUT_IDX_W'(r_pick0);
                            n_out.ring_slot  = OUT_IDX_W'(r_avail_idx[IDX_W-1:0]);
                            n_out.last       = 1'b1;
                            n_avail_idx      = r_avail_idx + 16'd1;
                            n_state          = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                // one descriptor per cycle
                if (!w_in_range || r_free[w_cur_idx]) begin
                    n_err   = 1'b1;
                    n_state = ST_REPORT;
                end else begin
                    n_free[w_cur_idx]  = 1'b1;
                    n_chain[w_cur_idx] = 1'b0;
                    n_next[w_cur_idx]  = '0;
                    if (r_chain[w_cur_idx] && (r_walk_cnt != IDX_W'(NUM_DESC - 1))) begin
                        n_cur      = HEAD_W'(r_next[w_cur_idx]);
                        n_walk_cnt = r_walk_cnt + 1'b1;
                    end else begin
                        n_state = ST_REPORT;
                    end
                end
            end

            ST_REPORT: begin
                if (w_can_emit) begin
                    n_out            = '0;
                    n_out_valid      = 1'b1;
                    n_out.kind       = r_err ? KIND_FREEERR : (r_bad ? KIND_BADSTAT : KIND_DONE);
                    n_out.desc_index = r_head[OUT_IDX_W-1:0];
                    n_out.last       = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

    // state, descriptor tables and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free      <= '1;
            r_chain     <= '{default: 1'b0};
            r_next      <= '{default: '0};
            r_avail_idx <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_chain     <= n_chain;
            r_next      <= n_next;
            r_avail_idx <= n_avail_idx;
            r_out_valid <= n_out_valid;
        end
        r_step      <= n_step;
        r_pick0     <= n_pick0;
        r_pick1     <= n_pick1;
        r_pick2     <= n_pick2;
        r_is_write  <= n_is_write;
        r_data_addr <= n_data_addr;
        r_head      <= n_head;
        r_cur       <= n_cur;
        r_walk_cnt  <= n_walk_cnt;
        r_err       <= n_err;
        r_bad       <= n_bad;
        r_out       <= n_out;
    end

endmodule
